[hw/rtl/qau_pkg.sv]
// Shared types, constants and arithmetic helpers of the quaternion unit.
`default_nettype none
package qau_pkg;

	localparam int QAU_CORDIC_STAGES = 24;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] ONE_Q24     = 34'sd16777216;

	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_MUL   = 2'd1,
		MODE_SCALE = 2'd2,
		MODE_ROT   = 2'd3
	} qau_mode_t;

	typedef struct packed {
		qau_mode_t          mode;
		logic signed [31:0] a_w;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_w;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] sf;
	} qau_op_t;

	typedef struct packed {
		logic signed [31:0] v;
		logic               ov;
	} qau_rs_t;

	typedef struct packed {
		logic signed [31:0] e0;
		logic signed [31:0] e1;
		logic signed [31:0] e2;
		logic signed [31:0] e3;
		logic               ov;
	} qau_row_t;

	typedef struct packed {
		qau_row_t r0;
		qau_row_t r1;
		qau_row_t r2;
		logic     rot;
	} qau_bundle_t;

	// Q16.48 sum -> Q8.24, round half up, saturate.
	function automatic qau_rs_t qau_rnd_sat(input logic signed [66:0] s);
		logic signed [66:0] r;
		qau_rs_t o;
		r = (s + 67'sd8388608) >>> 24;
		if (r > 67'sd2147483647) begin
			o.v  = 32'h7fffffff;
			o.ov = 1'b1;
		end else if (r < -67'sd2147483648) begin
			o.v  = 32'h80000000;
			o.ov = 1'b1;
		end else begin
			o.v  = r[31:0];
			o.ov = 1'b0;
		end
		return o;
	endfunction

	function automatic logic signed [63:0] qau_mul32(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return p;
	endfunction

	// arctangent of 2^-i in binary-angle units
	function automatic logic signed [31:0] qau_atan(input logic [4:0] i);
		logic signed [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/qau_cordic.sv]
// Pipelined CORDIC: sine and cosine in Q8.24, operand word carried alongside.
`default_nettype none
module qau_cordic import qau_pkg::*; #(
	parameter int STAGES = QAU_CORDIC_STAGES
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_vld,
	input  wire qau_op_t            in_op,
	input  wire logic        [31:0] in_angle,
	output logic                    out_vld,
	output qau_op_t                 out_op,
	output logic signed      [31:0] out_sin,
	output logic signed      [31:0] out_cos
);

	logic               vld_s [0:STAGES];
	qau_op_t            op_s  [0:STAGES];
	logic        [1:0]  q_s   [0:STAGES];
	logic signed [31:0] z_s   [0:STAGES];
	logic signed [33:0] x_s   [0:STAGES];
	logic signed [33:0] y_s   [0:STAGES];

	logic        [31:0] ang_p;
	logic        [1:0]  q_in;
	logic        [31:0] z_in;

	// nearest quarter turn, residual wraps into [-1/8, 1/8) turn
	assign ang_p = in_angle + 32'h20000000;
	assign q_in  = ang_p[31:30];
	assign z_in  = in_angle - {q_in, 30'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s[0] <= in_op;
			q_s[0]  <= q_in;
			z_s[0]  <= z_in;
			x_s[0]  <= CORDIC_GAIN;
			y_s[0]  <= 34'sd0;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				op_s[i+1] <= op_s[i];
				q_s[i+1]  <= q_s[i];
				if (!z_s[i][31]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - qau_atan(5'(i));
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + qau_atan(5'(i));
				end
			end
		end
	end

	logic signed [33:0] c_raw, s_raw, c_rnd, s_rnd;

	always_comb begin
		case (q_s[STAGES])
			2'd0: begin
				c_raw = x_s[STAGES];
				s_raw = y_s[STAGES];
			end
			2'd1: begin
				c_raw = -y_s[STAGES];
				s_raw = x_s[STAGES];
			end
			2'd2: begin
				c_raw = -x_s[STAGES];
				s_raw = -y_s[STAGES];
			end
			default: begin
				c_raw = y_s[STAGES];
				s_raw = -x_s[STAGES];
			end
		endcase
		c_rnd = (c_raw + 34'sd32) >>> 6;
		s_rnd = (s_raw + 34'sd32) >>> 6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= vld_s[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_op  <= op_s[STAGES];
			out_cos <= c_rnd[31:0];
			out_sin <= s_rnd[31:0];
		end
	end

endmodule
`default_nettype wire

[hw/rtl/qau_arith.sv]
// Product, rounding and matrix stages: four pipeline stages after the CORDIC.
`default_nettype none
module qau_arith import qau_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_vld,
	input  wire qau_op_t            in_op,
	input  wire logic signed [31:0] in_sin,
	input  wire logic signed [31:0] in_cos,
	output logic                    out_vld,
	output qau_bundle_t             out_bnd
);

	// ---------------- stage 1: products ----------------
	logic               vld_s1;
	qau_mode_t          mode_s1;
	logic signed [31:0] add_s1 [4];
	logic               addov_s1;
	logic signed [63:0] hp_s1  [4][4];
	logic signed [63:0] sp_s1  [4];
	logic signed [63:0] axp_s1 [6];
	logic signed [63:0] vs_s1  [3];
	logic signed [31:0] c_s1;
	logic signed [33:0] t_s1;

	logic signed [31:0] av [4];
	logic signed [31:0] bv [4];
	qau_rs_t            add_c [4];

	always_comb begin
		logic signed [32:0] s;
		av = '{in_op.a_w, in_op.a_x, in_op.a_y, in_op.a_z};
		bv = '{in_op.b_w, in_op.b_x, in_op.b_y, in_op.b_z};
		for (int k = 0; k < 4; k++) begin
			s = 33'(av[k]) + 33'(bv[k]);
			if (s > 33'sd2147483647) begin
				add_c[k].v  = 32'h7fffffff;
				add_c[k].ov = 1'b1;
			end else if (s < -33'sd2147483648) begin
				add_c[k].v  = 32'h80000000;
				add_c[k].ov = 1'b1;
			end else begin
				add_c[k].v  = s[31:0];
				add_c[k].ov = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1  <= in_op.mode;
			for (int k = 0; k < 4; k++) begin
				add_s1[k] <= add_c[k].v;
			end
			addov_s1 <= add_c[0].ov | add_c[1].ov | add_c[2].ov | add_c[3].ov;
			// Hamilton terms, sign applied in stage 2
			hp_s1[0][0] <= qau_mul32(in_op.a_w, in_op.b_w);
			hp_s1[0][1] <= qau_mul32(in_op.a_x, in_op.b_x);
			hp_s1[0][2] <= qau_mul32(in_op.a_y, in_op.b_y);
			hp_s1[0][3] <= qau_mul32(in_op.a_z, in_op.b_z);
			hp_s1[1][0] <= qau_mul32(in_op.a_w, in_op.b_x);
			hp_s1[1][1] <= qau_mul32(in_op.a_x, in_op.b_w);
			hp_s1[1][2] <= qau_mul32(in_op.a_y, in_op.b_z);
			hp_s1[1][3] <= qau_mul32(in_op.a_z, in_op.b_y);
			hp_s1[2][0] <= qau_mul32(in_op.a_w, in_op.b_y);
			hp_s1[2][1] <= qau_mul32(in_op.a_y, in_op.b_w);
			hp_s1[2][2] <= qau_mul32(in_op.a_z, in_op.b_x);
			hp_s1[2][3] <= qau_mul32(in_op.a_x, in_op.b_z);
			hp_s1[3][0] <= qau_mul32(in_op.a_w, in_op.b_z);
			hp_s1[3][1] <= qau_mul32(in_op.a_z, in_op.b_w);
			hp_s1[3][2] <= qau_mul32(in_op.a_x, in_op.b_y);
			hp_s1[3][3] <= qau_mul32(in_op.a_y, in_op.b_x);
			for (int k = 0; k < 4; k++) begin
				sp_s1[k] <= qau_mul32(av[k], in_op.sf);
			end
			axp_s1[0] <= qau_mul32(in_op.a_x, in_op.a_x);
			axp_s1[1] <= qau_mul32(in_op.a_x, in_op.a_y);
			axp_s1[2] <= qau_mul32(in_op.a_x, in_op.a_z);
			axp_s1[3] <= qau_mul32(in_op.a_y, in_op.a_y);
			axp_s1[4] <= qau_mul32(in_op.a_y, in_op.a_z);
			axp_s1[5] <= qau_mul32(in_op.a_z, in_op.a_z);
			vs_s1[0]  <= qau_mul32(in_op.a_x, in_sin);
			vs_s1[1]  <= qau_mul32(in_op.a_y, in_sin);
			vs_s1[2]  <= qau_mul32(in_op.a_z, in_sin);
			c_s1      <= in_cos;
			t_s1      <= ONE_Q24 - 34'(in_cos);
		end
	end

	// ---------------- stage 2: round quaternion results and axis products ----------------
	logic               vld_s2;
	qau_mode_t          mode_s2;
	logic signed [31:0] res_s2 [4];
	logic               resov_s2;
	logic signed [31:0] axq_s2 [6];
	logic               axov_s2 [6];
	logic signed [63:0] vs_s2  [3];
	logic signed [31:0] c_s2;
	logic signed [33:0] t_s2;

	qau_rs_t hm_c [4];
	qau_rs_t sc_c [4];
	qau_rs_t ax_c [6];

	always_comb begin
		hm_c[0] = qau_rnd_sat(67'(hp_s1[0][0]) - 67'(hp_s1[0][1])
			- 67'(hp_s1[0][2]) - 67'(hp_s1[0][3]));
		for (int r = 1; r < 4; r++) begin
			hm_c[r] = qau_rnd_sat(67'(hp_s1[r][0]) + 67'(hp_s1[r][1])
				+ 67'(hp_s1[r][2]) - 67'(hp_s1[r][3]));
		end
		for (int k = 0; k < 4; k++) begin
			sc_c[k] = qau_rnd_sat(67'(sp_s1[k]));
		end
		for (int k = 0; k < 6; k++) begin
			ax_c[k] = qau_rnd_sat(67'(axp_s1[k]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2 <= mode_s1;
			case (mode_s1)
				MODE_ADD: begin
					for (int k = 0; k < 4; k++) begin
						res_s2[k] <= add_s1[k];
					end
					resov_s2 <= addov_s1;
				end
				MODE_MUL: begin
					for (int k = 0; k < 4; k++) begin
						res_s2[k] <= hm_c[k].v;
					end
					resov_s2 <= hm_c[0].ov | hm_c[1].ov | hm_c[2].ov | hm_c[3].ov;
				end
				default: begin
					for (int k = 0; k < 4; k++) begin
						res_s2[k] <= sc_c[k].v;
					end
					resov_s2 <= sc_c[0].ov | sc_c[1].ov | sc_c[2].ov | sc_c[3].ov;
				end
			endcase
			for (int k = 0; k < 6; k++) begin
				axq_s2[k]  <= ax_c[k].v;
				axov_s2[k] <= ax_c[k].ov;
			end
			vs_s2 <= vs_s1;
			c_s2  <= c_s1;
			t_s2  <= t_s1;
		end
	end

	// ---------------- stage 3: axis products times (1 - cos) ----------------
	logic               vld_s3;
	qau_mode_t          mode_s3;
	logic signed [31:0] res_s3 [4];
	logic               resov_s3;
	logic signed [65:0] mt_s3  [6];
	logic               axov_s3 [6];
	logic signed [63:0] vs_s3  [3];
	logic signed [31:0] c_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s3  <= mode_s2;
			res_s3   <= res_s2;
			resov_s3 <= resov_s2;
			for (int k = 0; k < 6; k++) begin
				mt_s3[k] <= 66'(axq_s2[k]) * 66'(t_s2);
			end
			axov_s3 <= axov_s2;
			vs_s3   <= vs_s2;
			c_s3    <= c_s2;
		end
	end

	// ---------------- stage 4: matrix elements ----------------
	// axis index: xx xy xz yy yz zz; sine terms: x*s y*s z*s
	logic signed [66:0] c24;
	qau_rs_t            el [9];
	qau_bundle_t        bnd_c;

	always_comb begin
		c24   = 67'(c_s3) <<< 24;
		el[0] = qau_rnd_sat(67'(mt_s3[0]) + c24);
		el[1] = qau_rnd_sat(67'(mt_s3[1]) - 67'(vs_s3[2]));
		el[2] = qau_rnd_sat(67'(mt_s3[2]) + 67'(vs_s3[1]));
		el[3] = qau_rnd_sat(67'(mt_s3[1]) + 67'(vs_s3[2]));
		el[4] = qau_rnd_sat(67'(mt_s3[3]) + c24);
		el[5] = qau_rnd_sat(67'(mt_s3[4]) - 67'(vs_s3[0]));
		el[6] = qau_rnd_sat(67'(mt_s3[2]) - 67'(vs_s3[1]));
		el[7] = qau_rnd_sat(67'(mt_s3[4]) + 67'(vs_s3[0]));
		el[8] = qau_rnd_sat(67'(mt_s3[5]) + c24);

		bnd_c.rot = (mode_s3 == MODE_ROT);
		if (bnd_c.rot) begin
			bnd_c.r0 = '{el[0].v, el[1].v, el[2].v, 32'sd0,
				axov_s3[0] | axov_s3[1] | axov_s3[2] | el[0].ov | el[1].ov | el[2].ov};
		end else begin
			bnd_c.r0 = '{res_s3[0], res_s3[1], res_s3[2], res_s3[3], resov_s3};
		end
		bnd_c.r1 = '{el[3].v, el[4].v, el[5].v, 32'sd0,
			axov_s3[1] | axov_s3[3] | axov_s3[4] | el[3].ov | el[4].ov | el[5].ov};
		bnd_c.r2 = '{el[6].v, el[7].v, el[8].v, 32'sd0,
			axov_s3[2] | axov_s3[4] | axov_s3[5] | el[6].ov | el[7].ov | el[8].ov};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_bnd <= bnd_c;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/qau_out.sv]
// Output register: sends one word per result, three rows for a rotation matrix.
`default_nettype none
module qau_out import qau_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_vld,
	input  wire qau_bundle_t   in_bnd,
	output logic               take,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [127:0]       m_tdata,
	output logic               m_tlast,
	output logic               m_tuser
);

	qau_bundle_t bnd_q;
	logic        busy_q;
	logic [1:0]  idx_q;
	qau_row_t    row;
	logic        fin;

	always_comb begin
		case (idx_q)
			2'd0:    row = bnd_q.r0;
			2'd1:    row = bnd_q.r1;
			default: row = bnd_q.r2;
		endcase
		fin = !bnd_q.rot || (idx_q == 2'd2);
	end

	assign take     = !busy_q || (m_tready && fin);
	assign m_tvalid = busy_q;
	assign m_tdata  = {row.e3, row.e2, row.e1, row.e0};
	assign m_tlast  = fin;
	assign m_tuser  = row.ov;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (take) begin
			busy_q <= in_vld;
			idx_q  <= 2'd0;
		end else if (m_tready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bnd_q <= in_bnd;
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !bnd_q.rot |-> idx_q == 2'd0)
		else $error("row index past single result");
	a_idx_max: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd3)
		else $error("row index past third row");
	a_idle_take: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> take)
		else $error("pipeline stalled while output empty");
	a_mid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && m_tready && !fin |=> busy_q && idx_q == $past(idx_q) + 2'd1)
		else $error("matrix row skipped or dropped");

endmodule
`default_nettype wire

[hw/rtl/quaternion_arithmetic_unit_core.sv]
// Quaternion arithmetic unit top level: add, Hamilton product, scale, rotation matrix.
//
//  channel | dir | tdata                          | tuser      | tlast
//  s_*     | in  | a_w a_x a_y a_z b_w b_x b_y b_z | mode[1:0]  | -
//          |     | scale_factor angle (320 bits)  |            |
//  m_*     | out | res_a res_b res_c res_d (128)   | overflow   | last
//
// The path from input word to first output word runs through the CORDIC chain (one
// stage per iteration) plus split, finish, four arith stages and the output register.
// One item enters per cycle unless the output stalls; a rotation matrix is three words.
// Reset clears all valid bits; the datapath has no reset.
// A stall on m_tready freezes the whole pipeline; s_tready falls with it.
`default_nettype none
module quaternion_arithmetic_unit_core import qau_pkg::*; #(
	parameter int CORDIC_STAGES = QAU_CORDIC_STAGES
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [319:0] s_tdata,   // a_w a_x a_y a_z b_w b_x b_y b_z scale_factor angle
	input  wire logic [1:0]   s_tuser,   // mode
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata,   // res_a res_b res_c res_d
	output logic              m_tuser,   // overflow
	output logic              m_tlast
);

	logic        en;
	qau_op_t     op;
	logic [31:0] angle;

	logic               cd_vld;
	qau_op_t            cd_op;
	logic signed [31:0] cd_sin, cd_cos;

	logic        ar_vld;
	qau_bundle_t ar_bnd;

	assign op.mode = qau_mode_t'(s_tuser);
	assign op.a_w  = s_tdata[31:0];
	assign op.a_x  = s_tdata[63:32];
	assign op.a_y  = s_tdata[95:64];
	assign op.a_z  = s_tdata[127:96];
	assign op.b_w  = s_tdata[159:128];
	assign op.b_x  = s_tdata[191:160];
	assign op.b_y  = s_tdata[223:192];
	assign op.b_z  = s_tdata[255:224];
	assign op.sf   = s_tdata[287:256];
	assign angle   = s_tdata[319:288];

	assign s_tready = en;

	qau_cordic #(
		.STAGES(CORDIC_STAGES)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (s_tvalid),
		.in_op    (op),
		.in_angle (angle),
		.out_vld  (cd_vld),
		.out_op   (cd_op),
		.out_sin  (cd_sin),
		.out_cos  (cd_cos)
	);

	qau_arith u_arith (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (cd_vld),
		.in_op   (cd_op),
		.in_sin  (cd_sin),
		.in_cos  (cd_cos),
		.out_vld (ar_vld),
		.out_bnd (ar_bnd)
	);

	qau_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (ar_vld),
		.in_bnd   (ar_bnd),
		.take     (en),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire
